// ===== src/ccbg_pkg.sv =====
// ----------------------------------------------------------------------------
// ccbg_pkg
// Shared types and constants of the code cache budget governor: command
// codes, class codes, register indexes, reset values and default sizes.
// ----------------------------------------------------------------------------
package ccbg_pkg;

  // Default sizing of the slot table and of the byte counters.
  localparam int unsigned SLOT_COUNT_DEF = 16;
  localparam int unsigned BYTE_BITS_DEF  = 48;

  // Fixed field widths.
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned CLASS_W = 2;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned CPU_W   = 8;

  // Configuration port geometry: registers on 8-byte strides.
  localparam int unsigned APB_ADDR_W = 6;
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned REG_IDX_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESERVE = 3'd0,
    CMD_REFRESH = 3'd1,
    CMD_RECLASS = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_QUERY   = 3'd4
  } cmd_e;

  localparam logic [CLASS_W-1:0] CLASS_BOOT       = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_BACKGROUND = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_SLAB_CAP     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BUDGET_TOTAL = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_WORKING  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_BG_KEEP  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PRESSURE     = 3'd4;

  localparam logic [63:0] RST_SLAB_CAP     = 64'd16777216;
  localparam logic [63:0] RST_BUDGET_TOTAL = 64'd67108864;
  localparam logic [63:0] RST_MIN_WORKING  = 64'd1048576;
  localparam logic [63:0] RST_MAX_BG_KEEP  = 64'd4194304;

endpackage

// ===== src/code_cache_budget_governor_unit.sv =====
// ----------------------------------------------------------------------------
// code_cache_budget_governor_unit
// Slot table of code cache reservations with saturating byte totals,
// per-class retention targets and reclaimable excess reporting.
// ----------------------------------------------------------------------------
// Usage: each command item arrives on the slave stream. s_axis_tuser carries
// the command code, s_axis_tdata the slot, class, new actual byte count and
// processor count. Every item yields exactly one result item on the master
// stream: m_axis_tuser is the status flag, m_axis_tdata the slot's slab
// bytes, retention target, reclaimable bytes and the two running totals.
// The result is registered: the slot entry is read from the table RAM at
// acceptance, and the update and all result arithmetic run as the item moves
// from the input register into the result register. One item is accepted
// per cycle unless the receiver stalls; a command on the same slot as the item
// just ahead sees that item's write through a one-entry forwarding register.
// When the receiver stalls, the result register holds and the input
// register still takes one more item, after which s_axis_tready drops.
// Reset clears the totals to zero, loads the register defaults and empties
// the pipeline; slot entries are undefined until first written. The APB port
// must only be written while the stream is idle.
// ----------------------------------------------------------------------------
module code_cache_budget_governor_unit
  import ccbg_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int unsigned BYTE_BITS  = BYTE_BITS_DEF,
  localparam int unsigned IN_DATA_W  = ((SLOT_W + CLASS_W + BYTE_BITS + CPU_W + 7) / 8) * 8,
  localparam int unsigned OUT_DATA_W = ((5 * BYTE_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Command stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0 up: slot, class_code, new_actual, cpu_count.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0 up: cmd.
  input  logic [CMD_W-1:0]      s_axis_tuser,
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0 up: slab_bytes, keep_target, reclaim_bytes,
  // mapped_sum, actual_sum.
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Fields from bit 0 up: status.
  output logic                  m_axis_tuser,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned BB    = BYTE_BITS;
  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned ENT_W = CLASS_W + 2 * BB;

  function automatic logic [BB-1:0] umax(input logic [BB-1:0] a, input logic [BB-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [BB-1:0] umin(input logic [BB-1:0] a, input logic [BB-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [BB-1:0]        slab_cap_q, budget_q, mws_q, mbk_q;
  logic                 pressure_q;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[APB_ADDR_W-1:3];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slab_cap_q <= RST_SLAB_CAP[BB-1:0];
      budget_q   <= RST_BUDGET_TOTAL[BB-1:0];
      mws_q      <= RST_MIN_WORKING[BB-1:0];
      mbk_q      <= RST_MAX_BG_KEEP[BB-1:0];
      pressure_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SLAB_CAP:     slab_cap_q <= pwdata[BB-1:0];
        REG_BUDGET_TOTAL: budget_q   <= pwdata[BB-1:0];
        REG_MIN_WORKING:  mws_q      <= pwdata[BB-1:0];
        REG_MAX_BG_KEEP:  mbk_q      <= pwdata[BB-1:0];
        REG_PRESSURE:     pressure_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SLAB_CAP:     prdata = APB_DATA_W'(slab_cap_q);
      REG_BUDGET_TOTAL: prdata = APB_DATA_W'(budget_q);
      REG_MIN_WORKING:  prdata = APB_DATA_W'(mws_q);
      REG_MAX_BG_KEEP:  prdata = APB_DATA_W'(mbk_q);
      REG_PRESSURE:     prdata = APB_DATA_W'(pressure_q);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Targets derived from configuration. They only change when the registers
  // do, so they are registered once and are settled in the cycle after a write,
  // before any item that follows the write reaches the compute stage.
  // --------------------------------------------------------------------------
  logic [BB-1:0] cap_c, budget_eff_c, bg_floor_c, bg_press_c, norm_press_c;
  logic [BB-1:0] cap_q, budget_eff_q, keep_norm_q, keep_bg_q;

  always_comb begin
    cap_c        = umax(slab_cap_q, mws_q);
    budget_eff_c = umax(budget_q, mws_q);
    bg_floor_c   = umax(mws_q, umin(cap_c >> 2, mbk_q));
    bg_press_c   = pressure_q ? umax(mws_q, bg_floor_c >> 1) : bg_floor_c;
    norm_press_c = pressure_q ? umax(mws_q, cap_c >> 1) : cap_c;
  end

  always_ff @(posedge clk_i) begin
    cap_q        <= cap_c;
    budget_eff_q <= budget_eff_c;
    keep_norm_q  <= umin(norm_press_c, cap_c);
    keep_bg_q    <= umin(bg_press_c, cap_c);
  end

  // --------------------------------------------------------------------------
  // Input register and slot table read.
  // --------------------------------------------------------------------------
  logic               s1_valid_q;
  logic [CMD_W-1:0]   s1_cmd_q;
  logic [SLOT_W-1:0]  s1_slot_q;
  logic [CLASS_W-1:0] s1_cls_q;
  logic [BB-1:0]      s1_new_q;
  logic [CPU_W-1:0]   s1_cpu_q;
  logic               out_valid_q;
  logic               advance, accept;
  logic [31:0]        acc_slot_ext, s1_slot_ext;
  logic [IDX_W-1:0]   acc_idx, s1_idx;
  logic               s1_in_range;

  assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign acc_slot_ext = 32'(s_axis_tdata[SLOT_W-1:0]);
  assign acc_idx      = acc_slot_ext[IDX_W-1:0];
  assign s1_slot_ext  = 32'(s1_slot_q);
  assign s1_idx       = s1_slot_ext[IDX_W-1:0];
  assign s1_in_range  = s1_slot_ext < SLOT_COUNT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q  <= s_axis_tuser;
      s1_slot_q <= s_axis_tdata[SLOT_W-1:0];
      s1_cls_q  <= s_axis_tdata[SLOT_W +: CLASS_W];
      s1_new_q  <= s_axis_tdata[SLOT_W+CLASS_W +: BB];
      s1_cpu_q  <= s_axis_tdata[SLOT_W+CLASS_W+BB +: CPU_W];
    end
  end

  // Table entries pack class, slab bytes and actual bytes from bit 0 up.
  logic             tbl_we;
  logic [ENT_W-1:0] tbl_wdata, tbl_rdata;

  ccbg_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (s1_idx),
    .wdata_i (tbl_wdata),
    .re_i    (accept),
    .raddr_i (acc_idx),
    .rdata_o (tbl_rdata)
  );

  // The item ahead may write the very entry this item reads in the same
  // cycle; the written value is captured here and replaces the RAM data.
  logic             fwd_q;
  logic [ENT_W-1:0] fwd_ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (accept) begin
      fwd_q <= tbl_we && (s1_idx == acc_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_ent_q <= tbl_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Command execution.
  // --------------------------------------------------------------------------
  logic [BB-1:0]      mapped_q, actual_q, mapped_d, actual_d;
  logic [ENT_W-1:0]   ent;
  logic [CLASS_W-1:0] old_cls, nxt_cls;
  logic [BB-1:0]      old_slab, old_act, nxt_slab, nxt_act;
  logic [BB:0]        map_add, map_sub, act_sub;
  logic [BB+1:0]      act_move;
  logic               status_d;
  logic [BB-1:0]      keep_c, slab_out, keep_out, reclaim_out;
  logic               over_budget;

  assign ent      = fwd_q ? fwd_ent_q : tbl_rdata;
  assign old_cls  = ent[CLASS_W-1:0];
  assign old_slab = ent[CLASS_W +: BB];
  assign old_act  = ent[CLASS_W+BB +: BB];

  // Saturating and flooring arithmetic on the totals. The refresh move is a
  // single three-input sum whose sign and carry pick floor or saturation.
  assign map_add  = {1'b0, mapped_q} + {1'b0, cap_q};
  assign map_sub  = {1'b0, mapped_q} - {1'b0, old_slab};
  assign act_sub  = {1'b0, actual_q} - {1'b0, old_act};
  assign act_move = {2'b00, actual_q} + {2'b00, s1_new_q} - {2'b00, old_act};

  always_comb begin
    nxt_cls  = old_cls;
    nxt_slab = old_slab;
    nxt_act  = old_act;
    mapped_d = mapped_q;
    actual_d = actual_q;
    status_d = 1'b0;
    if (s1_in_range) begin
      unique case (s1_cmd_q)
        CMD_RESERVE: begin
          if (s1_cpu_q == '0) begin
            status_d = 1'b1;
          end else begin
            nxt_cls  = s1_cls_q;
            nxt_slab = cap_q;
            nxt_act  = '0;
            mapped_d = map_add[BB] ? '1 : map_add[BB-1:0];
          end
        end
        CMD_REFRESH: begin
          nxt_act = s1_new_q;
          if (act_move[BB+1]) begin
            actual_d = '0;
          end else if (act_move[BB]) begin
            actual_d = '1;
          end else begin
            actual_d = act_move[BB-1:0];
          end
        end
        CMD_RECLASS: begin
          nxt_cls = s1_cls_q;
        end
        CMD_RELEASE: begin
          mapped_d = map_sub[BB] ? '0 : map_sub[BB-1:0];
          actual_d = act_sub[BB] ? '0 : act_sub[BB-1:0];
          nxt_slab = '0;
          nxt_act  = '0;
        end
        default: ;  // query and the unused codes only report
      endcase
    end
  end

  // Writing back unchanged data on a query is harmless and keeps the
  // forwarding condition simple.
  assign tbl_we    = advance && s1_in_range;
  assign tbl_wdata = {nxt_act, nxt_slab, nxt_cls};

  // The unused class code behaves as normal.
  always_comb begin
    case (nxt_cls)
      CLASS_BOOT:       keep_c = cap_q;
      CLASS_BACKGROUND: keep_c = keep_bg_q;
      default:          keep_c = keep_norm_q;
    endcase
  end

  assign over_budget = pressure_q || (actual_d > budget_eff_q);

  always_comb begin
    slab_out    = '0;
    keep_out    = '0;
    reclaim_out = '0;
    if (s1_in_range) begin
      slab_out = nxt_slab;
      keep_out = keep_c;
      if (over_budget && (nxt_cls != CLASS_BOOT) && (nxt_act > keep_c)) begin
        reclaim_out = nxt_act - keep_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mapped_q <= '0;
      actual_q <= '0;
    end else if (advance) begin
      mapped_q <= mapped_d;
      actual_q <= actual_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_status_q <= status_d;
      out_data_q   <= OUT_DATA_W'({actual_d, mapped_d, reclaim_out, keep_out, slab_out});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

endmodule

// ===== src/ccbg_ram.sv =====
// ----------------------------------------------------------------------------
// ccbg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ccbg_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
